/* design/assert_macros.svh */
// Assertion macros used by the checker file bwlp_checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_ON_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/bwlp_pkg.sv */
// Types and constants for the variable time step Butterworth low-pass filter.
// No dependencies.
package bwlp_pkg;

  localparam int DATA_W  = 32;
  localparam int STAMP_W = 32;
  localparam int CUT_W   = 17;
  localparam int K_W     = 49;
  localparam int DVD_W   = 64;
  localparam int DVS_W   = 40;
  localparam int QUO_W   = 32;

  localparam logic [CUT_W-1:0] CUT_RESET = 17'd1000;
  localparam logic [26:0] HALF_TURN = 27'd100000000;
  localparam logic [26:0] HALF_HALF = 27'd50000000;
  localparam logic [31:0] PI_Q30    = 32'd3373259426;
  localparam logic [30:0] SQRT2_Q30 = 31'd1518500250;

  typedef enum logic [1:0] {
    KIND_FILTER = 2'd0,
    KIND_SHIFT  = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_t;

  typedef struct packed {
    logic                     action;
    logic signed [DATA_W-1:0] sample;
    logic [STAMP_W-1:0]       stamp_us;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] filtered;
    logic                     updated;
  } out_item_t;

  typedef struct packed {
    kind_t                    kind;
    logic signed [DATA_W-1:0] sample;
    logic [K_W-1:0]           k;
  } job_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dvd;
    logic [DVS_W-1:0] dvs;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quot;
    logic [DVD_W-1:0] rem;
  } div_rsp_t;

  // Arctangent of 2^-i in Q30 radians.
  function automatic logic [31:0] atan_q30(input logic [5:0] i);
    logic [31:0] v;
    case (i)
      6'd0: v = 32'd843314857;
      6'd1: v = 32'd497837829;
      6'd2: v = 32'd263043837;
      6'd3: v = 32'd133525159;
      6'd4: v = 32'd67021687;
      6'd5: v = 32'd33543516;
      6'd6: v = 32'd16775851;
      6'd7: v = 32'd8388437;
      6'd8: v = 32'd4194283;
      6'd9: v = 32'd2097149;
      default: begin
        if (i <= 6'd30) v = 32'd1 << (6'd30 - i);
        else v = 32'd0;
      end
    endcase
    return v;
  endfunction

endpackage

/* design/bwlp_front.sv */
// Front end: cutoff register, stamp tracking and item classification.
// Depends on bwlp_pkg.
module bwlp_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [bwlp_pkg::CUT_W-1:0] cfg_wdata,
  input  logic                     in_push,
  input  bwlp_pkg::in_item_t       in_item,
  input  logic                     q_full,
  output logic                     q_push,
  output bwlp_pkg::job_t           q_job
);

  logic [bwlp_pkg::CUT_W-1:0]   cutoff_r;
  logic [bwlp_pkg::STAMP_W-1:0] last_stamp_r;
  logic                         stamp_seen_r;
  logic [bwlp_pkg::STAMP_W-1:0] dt;
  logic                         accept;

  assign accept = in_push && !q_full;
  assign q_push = accept;
  assign dt     = in_item.stamp_us - last_stamp_r;

  // Classify the item and form cutoff * dt
  always_comb begin
    q_job.sample = in_item.sample;
    q_job.k      = bwlp_pkg::K_W'(cutoff_r) * bwlp_pkg::K_W'(dt);
    if (in_item.action) begin
      q_job.kind = bwlp_pkg::KIND_CLEAR;
    end else if (!stamp_seen_r || dt == '0) begin
      q_job.kind = bwlp_pkg::KIND_SHIFT;
    end else begin
      q_job.kind = bwlp_pkg::KIND_FILTER;
    end
  end

  // Hold the cutoff and the last stamp
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r     <= bwlp_pkg::CUT_RESET;
      last_stamp_r <= '0;
      stamp_seen_r <= 1'b0;
    end else begin
      if (cfg_we) cutoff_r <= cfg_wdata;
      if (accept && !in_item.action) begin
        stamp_seen_r <= 1'b1;
        last_stamp_r <= in_item.stamp_us;
      end
    end
  end

endmodule

/* design/bwlp_queue.sv */
// Two-entry job queue between front end and back end.
// Depends on bwlp_pkg.
module bwlp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bwlp_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output bwlp_pkg::job_t pop_job
);

  localparam int Depth = 2;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  bwlp_pkg::job_t  mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] rd_ptr_r;
  logic [CntW-1:0] count_r;
  logic            push_ok;
  logic            pop_ok;

  assign full    = (count_r == CntW'(Depth));
  assign empty   = (count_r == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign pop_job = mem_r[rd_ptr_r];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_ok) wr_ptr_r <= wr_ptr_r + PtrW'(1);
      if (pop_ok) rd_ptr_r <= rd_ptr_r + PtrW'(1);
      if (push_ok && !pop_ok) count_r <= count_r + CntW'(1);
      else if (!push_ok && pop_ok) count_r <= count_r - CntW'(1);
    end
  end

  // Store the pushed job
  always_ff @(posedge clk) begin
    if (push_ok) mem_r[wr_ptr_r] <= push_job;
  end

endmodule

/* design/bwlp_div.sv */
// Shared restoring divider, one quotient bit per cycle.
// Depends on bwlp_pkg.
module bwlp_div (
  input  logic               clk,
  input  logic               rst_n,
  input  bwlp_pkg::div_req_t req,
  output bwlp_pkg::div_rsp_t rsp
);

  localparam int DsW  = bwlp_pkg::DVS_W + bwlp_pkg::QUO_W - 1;
  localparam int PadW = DsW - bwlp_pkg::DVD_W;
  localparam int CntW = $clog2(bwlp_pkg::QUO_W + 1);

  logic [bwlp_pkg::DVD_W-1:0] rem_r;
  logic [DsW-1:0]             ds_r;
  logic [bwlp_pkg::QUO_W-1:0] quot_r;
  logic [CntW-1:0]            cnt_r;
  logic                       run_r;
  logic                       done_r;
  logic                       ge;

  assign ge       = {{PadW{1'b0}}, rem_r} >= ds_r;
  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = rem_r;

  // Sequence the steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= CntW'(bwlp_pkg::QUO_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - CntW'(1);
        if (cnt_r == CntW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Subtract the shifted divisor where it fits
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= req.dvd;
      ds_r   <= {req.dvs, {(bwlp_pkg::QUO_W - 1){1'b0}}};
      quot_r <= '0;
    end else if (run_r) begin
      if (ge) rem_r <= rem_r - ds_r[bwlp_pkg::DVD_W-1:0];
      quot_r <= {quot_r[bwlp_pkg::QUO_W-2:0], ge};
      ds_r   <= ds_r >> 1;
    end
  end

endmodule

/* design/bwlp_back.sv */
// Back end: angle reduction, CORDIC, coefficients, biquad and result register.
// Depends on bwlp_pkg and bwlp_div.
module bwlp_back #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  bwlp_pkg::job_t      q_job,
  output logic                q_pop,
  input  logic                out_pop,
  output logic                out_empty,
  output bwlp_pkg::out_item_t out_item
);

  localparam int StepW = $clog2(CORDIC_STEPS);
  localparam int AccW  = 70;
  localparam int DW    = bwlp_pkg::DATA_W;
  localparam logic [2:0] MacLast = 3'd5;
  localparam logic signed [33:0] OneQ30 = 34'sd1073741824;
  localparam logic signed [31:0] CLimit = 32'sd1677721600;
  localparam logic signed [40:0] One24 = 41'sd16777216;
  localparam logic signed [40:0] Two24 = 41'sd33554432;
  localparam logic signed [AccW-1:0] RoundHalf = AccW'(64'sd8388608);
  localparam logic signed [45:0] SatMax = 46'sd2147483647;
  localparam logic signed [45:0] SatMin = -46'sd2147483648;
  // Reciprocals of 10^8: floor(2^57 / 10^8) and floor(2^58 / 10^8)
  localparam logic [30:0] ModRecip = 31'd1441151880;
  localparam logic [31:0] AngRecip = 32'd2882303761;
  localparam logic [28:0] RedTurn  = 29'd100000000;
  localparam logic [28:0] RedTwo   = 29'd200000000;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MOD_EST, ST_MOD_REM, ST_MOD_FIX, ST_ANG_MUL, ST_ANG_EST, ST_ANG_REM,
    ST_ANG_FIX, ST_CORDIC, ST_CLAMP, ST_C_DIV, ST_MUL_C2, ST_MUL_S2C, ST_COEF, ST_G_DIV,
    ST_N2_DIV, ST_N1_DIV, ST_MAC, ST_ROUND, ST_FINISH
  } state_t;

  state_t                   state_r;
  bwlp_pkg::job_t           job_r;
  bwlp_pkg::div_req_t       div_req_r;
  bwlp_pkg::div_rsp_t       div_rsp;
  bwlp_pkg::out_item_t      out_item_r;
  logic                     out_valid_r;
  logic signed [DW-1:0]     ih_r [2];
  logic signed [DW-1:0]     oh_r [2];
  logic [25:0]              mag_r;
  logic                     neg_r;
  logic                     pos_r;
  logic [57:0]              prod_r;
  logic [31:0]              qe_r;
  logic [28:0]              red_r;
  logic signed [33:0]       x_r, y_r, z_r;
  logic [StepW-1:0]         step_r;
  logic                     div_neg_r;
  logic signed [31:0]       c_r;
  logic signed [40:0]       c2_r, s2c_r, b2_r, b1_r;
  logic signed [31:0]       g_r, n2_r, n1_r;
  logic signed [AccW-1:0]   acc_r;
  logic [2:0]               mac_idx_r;
  logic signed [DW-1:0]     res_r;

  logic                     out_free;
  logic [26:0]              r_val;
  logic [31:0]              z_fix;
  logic signed [33:0]       dx, dy, t, zq_s;
  logic [33:0]              ax, ay;
  logic                     clamp_hit;
  logic signed [32:0]       quot_s, quot_neg;
  logic signed [63:0]       c_sq, c_s2;
  logic signed [40:0]       a0_raw, b2_val, b1_val;
  logic [39:0]              a0_val;
  logic [40:0]              abs_b2, abs_b1;
  logic signed [33:0]       vsum, v_sel;
  logic signed [32:0]       coef_sel;
  logic signed [17:0]       slc;
  logic signed [50:0]       mac_prod;
  logic signed [AccW-1:0]   mac_term;
  logic signed [45:0]       res_full;
  logic signed [DW-1:0]     res_sat;

  bwlp_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req_r),
    .rsp (div_rsp)
  );

  assign q_pop     = (state_r == ST_IDLE) && !q_empty;
  assign out_empty = !out_valid_r;
  assign out_item  = out_item_r;
  assign out_free  = !out_valid_r || out_pop;

  // Datapath helpers
  always_comb begin
    r_val     = (red_r >= RedTurn) ? 27'(red_r - RedTurn) : red_r[26:0];
    z_fix     = qe_r + ((red_r >= RedTwo) ? 32'd2 : ((red_r >= RedTurn) ? 32'd1 : 32'd0));
    zq_s      = $signed({2'b00, z_fix});
    quot_s    = $signed({1'b0, div_rsp.quot});
    quot_neg  = -quot_s;
    dx        = y_r >>> step_r;
    dy        = x_r >>> step_r;
    t         = $signed({2'b00, bwlp_pkg::atan_q30(6'(step_r))});
    ax        = x_r[33] ? 34'(-x_r) : 34'(x_r);
    ay        = y_r[33] ? 34'(-y_r) : 34'(y_r);
    clamp_hit = (y_r == '0) || ((41'(ay) * 41'd100) < 41'(ax));
    c_sq      = 64'(c_r) * 64'(c_r);
    c_s2      = 64'(c_r) * $signed({33'd0, bwlp_pkg::SQRT2_Q30});
    a0_raw    = One24 + c2_r + s2c_r;
    a0_val    = (a0_raw < 41'sd1) ? 40'd1 : a0_raw[39:0];
    b2_val    = c2_r - s2c_r + One24;
    b1_val    = Two24 - (c2_r <<< 1);
    abs_b2    = b2_r[40] ? 41'(-b2_r) : 41'(b2_r);
    abs_b1    = b1_r[40] ? 41'(-b1_r) : 41'(b1_r);
    vsum      = 34'(job_r.sample) + (34'(ih_r[0]) <<< 1) + 34'(ih_r[1]);
    case (mac_idx_r[2:1])
      2'd0: begin coef_sel = 33'(g_r); v_sel = vsum; end
      2'd1: begin coef_sel = -33'(n2_r); v_sel = 34'(oh_r[1]); end
      2'd2: begin coef_sel = -33'(n1_r); v_sel = 34'(oh_r[0]); end
      default: begin coef_sel = '0; v_sel = '0; end
    endcase
    slc      = mac_idx_r[0] ? $signed({v_sel[33], v_sel[33:17]})
                            : $signed({1'b0, v_sel[16:0]});
    mac_prod = 51'(coef_sel) * 51'(slc);
    mac_term = mac_idx_r[0] ? (AccW'(mac_prod) <<< 17) : AccW'(mac_prod);
    res_full = 46'((acc_r + RoundHalf) >>> 24);
    if (res_full > SatMax) res_sat = DW'(SatMax);
    else if (res_full < SatMin) res_sat = DW'(SatMin);
    else res_sat = DW'(res_full);
  end

  // Sequence one job at a time; hold state, histories and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      out_valid_r     <= 1'b0;
      div_req_r.start <= 1'b0;
      ih_r[0]         <= '0;
      ih_r[1]         <= '0;
      oh_r[0]         <= '0;
      oh_r[1]         <= '0;
    end else begin
      div_req_r.start <= 1'b0;
      if (out_pop && out_valid_r) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            job_r <= q_job;
            if (q_job.kind == bwlp_pkg::KIND_FILTER) begin
              state_r <= ST_MOD_EST;
            end else begin
              state_r <= ST_FINISH;
            end
          end
        end
        // Reduce cutoff * dt modulo 10^8: reciprocal estimate, then one correction
        ST_MOD_EST: begin
          qe_r    <= 32'((60'(job_r.k[48:20]) * 60'(ModRecip)) >> 37);
          state_r <= ST_MOD_REM;
        end
        ST_MOD_REM: begin
          red_r   <= job_r.k[28:0] - 29'(qe_r) * 29'(bwlp_pkg::HALF_TURN);
          state_r <= ST_MOD_FIX;
        end
        ST_MOD_FIX: begin
          if (r_val <= bwlp_pkg::HALF_HALF) begin
            mag_r <= 26'(r_val);
            neg_r <= 1'b0;
            pos_r <= (r_val != '0);
          end else begin
            mag_r <= 26'(bwlp_pkg::HALF_TURN - r_val);
            neg_r <= 1'b1;
            pos_r <= 1'b0;
          end
          state_r <= ST_ANG_MUL;
        end
        // Scale to Q30 radians: round(mag * pi_q30 / 10^8)
        ST_ANG_MUL: begin
          prod_r  <= 58'(mag_r) * 58'(bwlp_pkg::PI_Q30) + 58'(bwlp_pkg::HALF_HALF);
          state_r <= ST_ANG_EST;
        end
        ST_ANG_EST: begin
          qe_r    <= 32'((64'(prod_r[57:26]) * 64'(AngRecip)) >> 32);
          state_r <= ST_ANG_REM;
        end
        ST_ANG_REM: begin
          red_r   <= prod_r[28:0] - 29'(qe_r) * 29'(bwlp_pkg::HALF_TURN);
          state_r <= ST_ANG_FIX;
        end
        ST_ANG_FIX: begin
          z_r     <= neg_r ? -zq_s : zq_s;
          x_r     <= OneQ30;
          y_r     <= '0;
          step_r  <= '0;
          state_r <= ST_CORDIC;
        end
        ST_CORDIC: begin
          if (!z_r[33]) begin
            x_r <= x_r - dx;
            y_r <= y_r + dy;
            z_r <= z_r - t;
          end else begin
            x_r <= x_r + dx;
            y_r <= y_r - dy;
            z_r <= z_r + t;
          end
          step_r <= step_r + StepW'(1);
          if (step_r == StepW'(CORDIC_STEPS - 1)) state_r <= ST_CLAMP;
        end
        ST_CLAMP: begin
          if (clamp_hit) begin
            c_r     <= pos_r ? CLimit : -CLimit;
            state_r <= ST_MUL_C2;
          end else begin
            div_req_r.start <= 1'b1;
            div_req_r.dvd   <= 64'(ax) << 24;
            div_req_r.dvs   <= 40'(ay);
            div_neg_r       <= x_r[33] ^ y_r[33];
            state_r         <= ST_C_DIV;
          end
        end
        ST_C_DIV: begin
          if (div_rsp.done) begin
            c_r     <= div_neg_r ? quot_neg[31:0] : quot_s[31:0];
            state_r <= ST_MUL_C2;
          end
        end
        ST_MUL_C2: begin
          c2_r    <= 41'(c_sq >>> 24);
          state_r <= ST_MUL_S2C;
        end
        ST_MUL_S2C: begin
          s2c_r   <= 41'(c_s2 >>> 30);
          state_r <= ST_COEF;
        end
        ST_COEF: begin
          b2_r            <= b2_val;
          b1_r            <= b1_val;
          div_req_r.start <= 1'b1;
          div_req_r.dvd   <= 64'd1 << 48;
          div_req_r.dvs   <= a0_val;
          state_r         <= ST_G_DIV;
        end
        ST_G_DIV: begin
          if (div_rsp.done) begin
            g_r             <= quot_s[31:0];
            div_req_r.start <= 1'b1;
            div_req_r.dvd   <= 64'(abs_b2) << 24;
            div_neg_r       <= b2_r[40];
            state_r         <= ST_N2_DIV;
          end
        end
        ST_N2_DIV: begin
          if (div_rsp.done) begin
            n2_r            <= div_neg_r ? quot_neg[31:0] : quot_s[31:0];
            div_req_r.start <= 1'b1;
            div_req_r.dvd   <= 64'(abs_b1) << 24;
            div_neg_r       <= b1_r[40];
            state_r         <= ST_N1_DIV;
          end
        end
        ST_N1_DIV: begin
          if (div_rsp.done) begin
            n1_r      <= div_neg_r ? quot_neg[31:0] : quot_s[31:0];
            acc_r     <= '0;
            mac_idx_r <= '0;
            state_r   <= ST_MAC;
          end
        end
        ST_MAC: begin
          acc_r     <= acc_r + mac_term;
          mac_idx_r <= mac_idx_r + 3'd1;
          if (mac_idx_r == MacLast) state_r <= ST_ROUND;
        end
        ST_ROUND: begin
          res_r   <= res_sat;
          state_r <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            case (job_r.kind)
              bwlp_pkg::KIND_CLEAR: begin
                ih_r[0] <= '0;
                ih_r[1] <= '0;
                oh_r[0] <= '0;
                oh_r[1] <= '0;
                out_item_r.filtered <= '0;
                out_item_r.updated  <= 1'b0;
              end
              bwlp_pkg::KIND_FILTER: begin
                ih_r[0] <= job_r.sample;
                ih_r[1] <= ih_r[0];
                oh_r[0] <= res_r;
                oh_r[1] <= oh_r[0];
                out_item_r.filtered <= res_r;
                out_item_r.updated  <= 1'b1;
              end
              default: begin
                ih_r[0] <= job_r.sample;
                ih_r[1] <= ih_r[0];
                out_item_r.filtered <= oh_r[0];
                out_item_r.updated  <= 1'b0;
              end
            endcase
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

/* design/butterworth_lowpass_variable_dt.sv */
// A clear or history-only item goes from ST_IDLE straight to ST_FINISH, which registers
// its result; a filtered sample also runs CORDIC and the shared one-bit-per-cycle divider,
// four times, or three when the tangent clamp applies, before the biquad and ST_FINISH.
// Throughput: one item at a time in the back end; a two-entry queue and the result
// register let the input side take items while results wait.
// Reset (rst_n low, synchronous) clears histories, stamp state and queues; cutoff = 10 Hz.
module butterworth_lowpass_variable_dt #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [bwlp_pkg::CUT_W-1:0] cfg_wdata,
  input  logic                     in_push,
  output logic                     in_full,
  input  bwlp_pkg::in_item_t       in_item,
  output logic                     out_empty,
  input  logic                     out_pop,
  output bwlp_pkg::out_item_t      out_item
);

  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_empty;
  bwlp_pkg::job_t push_job;
  bwlp_pkg::job_t pop_job;

  assign in_full = q_full;

  bwlp_front u_front (
    .clk (clk),
    .rst_n (rst_n),
    .cfg_we (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_push (in_push),
    .in_item (in_item),
    .q_full (q_full),
    .q_push (q_push),
    .q_job (push_job)
  );

  bwlp_queue u_queue (
    .clk (clk),
    .rst_n (rst_n),
    .push (q_push),
    .push_job (push_job),
    .full (q_full),
    .pop (q_pop),
    .empty (q_empty),
    .pop_job (pop_job)
  );

  bwlp_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk (clk),
    .rst_n (rst_n),
    .q_empty (q_empty),
    .q_job (pop_job),
    .q_pop (q_pop),
    .out_pop (out_pop),
    .out_empty (out_empty),
    .out_item (out_item)
  );

endmodule

/* design/bwlp_checker.sv */
// Port-level checks for the filter top level, attached by bind.
// Depends on bwlp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bwlp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_push,
  input logic                in_full,
  input logic                out_empty,
  input logic                out_pop,
  input bwlp_pkg::out_item_t out_item
);

  logic [2:0] pending_r;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = in_push && !in_full;
  assign out_xfer = out_pop && !out_empty;

  // Count items taken whose result has not been transferred yet
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else if (in_xfer && !out_xfer) begin
      pending_r <= pending_r + 3'd1;
    end else if (!in_xfer && out_xfer) begin
      pending_r <= pending_r - 3'd1;
    end
  end

  `ASSERT_ON_CLK(a_result_holds, clk, rst_n, !out_empty && !out_pop |=> !out_empty && $stable(out_item), "waiting result changed")
  `ASSERT_ON_CLK(a_result_has_item, clk, rst_n, !out_empty |-> pending_r != 3'd0, "result without a taken item")
  `ASSERT_ON_CLK(a_full_needs_items, clk, rst_n, in_full |-> pending_r >= 3'd2, "full with too few items in flight")
  `ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> out_empty && !in_full, "reset left items behind")

endmodule

bind butterworth_lowpass_variable_dt bwlp_checker u_bwlp_checker (
  .clk (clk),
  .rst_n (rst_n),
  .in_push (in_push),
  .in_full (in_full),
  .out_empty (out_empty),
  .out_pop (out_pop),
  .out_item (out_item)
);
